@@ src/rep_pkg.sv @@
// rep_pkg: shared types, codes and constants of the rumble envelope pulse driver
// used by rep_ctrl, rep_dp and rumble_envelope_pulse_driver; no dependencies
package rep_pkg;

	// default number of controller ports
	localparam int PORTS_DEF = 4;

	// request function codes
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	// motor command codes
	localparam logic [1:0] MOTOR_NONE  = 2'd0;
	localparam logic [1:0] MOTOR_START = 2'd1;
	localparam logic [1:0] MOTOR_STOP  = 2'd2;

	// level thresholds and pulse accumulator constants
	localparam logic [7:0] LVL_START = 8'd71;
	localparam logic [7:0] LVL_STOP  = 8'd6;
	localparam logic [9:0] ACC_STEP  = 10'd256;
	localparam logic [9:0] ACC_BIAS  = 10'd4;

	// shared probe counter limit
	localparam logic [5:0] PROBE_LIMIT = 6'd60;

	// restoring divider: one quotient bit per step over the 24-bit product
	localparam int DIV_STEPS = 24;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_LEVEL,
		ST_SQR,
		ST_CUBE,
		ST_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic div_init;
		logic div_step;
		logic level;
		logic square;
		logic cube;
		logic commit;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic calc;
	} dp_status_t;

endpackage

@@ src/rep_dp.sv @@
// rep_dp: per-port ramp state, ramp multiply and divide, cube and motor decision
// depends on rep_pkg; driven by rep_ctrl through dp_cmd_t
module rep_dp #(
	parameter int PORTS = rep_pkg::PORTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rep_pkg::dp_cmd_t    cmd,
	output rep_pkg::dp_status_t status,
	input  logic                func,
	input  logic [1:0]          controller,
	input  logic                pak_present,
	input  logic [7:0]          start_level,
	input  logic [7:0]          end_level,
	input  logic [15:0]         duration,
	output logic [1:0]          motor_cmd,
	output logic                probe_request,
	output logic [7:0]          level
);

	localparam int         IDX_W   = (PORTS > 1) ? $clog2(PORTS) : 1;
	localparam logic [2:0] PORTS_C = 3'(PORTS);

	// captured request
	logic        func_q;
	logic [1:0]  port_q;
	logic        pak_q;
	logic [7:0]  start_in_q;
	logic [7:0]  end_in_q;
	logic [15:0] dur_in_q;

	// per-port state
	logic [7:0]  ramp_start_q [PORTS];
	logic [7:0]  ramp_end_q [PORTS];
	logic [15:0] ramp_length_q [PORTS];
	logic [15:0] ramp_remaining_q [PORTS];
	logic        motor_running_q [PORTS];
	logic [9:0]  pulse_acc_q [PORTS];
	logic [5:0]  probe_wait_q;

	// arithmetic registers
	logic        neg_q;
	logic [23:0] quot_q;
	logic [15:0] part_q;
	logic [7:0]  level_q;
	logic [15:0] sq_q;
	logic [23:0] cube_q;

	// output registers
	logic [1:0]  motor_cmd_q;
	logic        probe_q;
	logic [7:0]  level_out_q;

	logic             in_range;
	logic [IDX_W-1:0] idx;
	logic [7:0]       cur_start;
	logic [7:0]       cur_end;
	logic [15:0]      cur_len;
	logic [15:0]      cur_rem;
	logic             cur_run;
	logic [9:0]       cur_acc;
	logic             ramp_on;
	logic [15:0]      rem_dec;

	// capture request on accept
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q     <= func;
			port_q     <= controller;
			pak_q      <= pak_present;
			start_in_q <= start_level;
			end_in_q   <= end_level;
			dur_in_q   <= duration;
		end
	end

	// port select and current state read
	assign in_range  = {1'b0, port_q} < PORTS_C;
	assign idx       = port_q[IDX_W-1:0];
	assign cur_start = ramp_start_q[idx];
	assign cur_end   = ramp_end_q[idx];
	assign cur_len   = ramp_length_q[idx];
	assign cur_rem   = ramp_remaining_q[idx];
	assign cur_run   = motor_running_q[idx];
	assign cur_acc   = pulse_acc_q[idx];
	assign ramp_on   = cur_len != 16'd0;
	assign rem_dec   = cur_rem - 16'd1;

	assign status.calc = in_range && (func_q == rep_pkg::FUNC_TICK) && pak_q;

	// ramp product magnitude: |end - start| * (length - remaining)
	logic signed [8:0] diff_s;
	logic [7:0]        diff_mag;
	logic [15:0]       span;
	logic [23:0]       prod;

	assign diff_s   = $signed({1'b0, cur_end}) - $signed({1'b0, cur_start});
	assign diff_mag = diff_s[8] ? 8'(-diff_s) : diff_s[7:0];
	assign span     = cur_len - cur_rem;
	assign prod     = {16'd0, diff_mag} * {8'd0, span};

	// restoring divide step
	logic [16:0] shifted;
	logic        fits;

	assign shifted = {part_q, quot_q[23]};
	assign fits    = shifted >= {1'b0, cur_len};

	// level: start plus signed quotient, clamped; zero when no ramp is loaded
	logic signed [25:0] lvl_sum;
	logic [7:0]         lvl_clamp;

	always_comb begin
		if (neg_q) begin
			lvl_sum = $signed({18'd0, cur_start}) - $signed({2'd0, quot_q});
		end else begin
			lvl_sum = $signed({18'd0, cur_start}) + $signed({2'd0, quot_q});
		end
		priority if (!ramp_on) begin
			lvl_clamp = 8'd0;
		end else if (lvl_sum < 0) begin
			lvl_clamp = 8'd0;
		end else if (lvl_sum > 26'sd255) begin
			lvl_clamp = 8'd255;
		end else begin
			lvl_clamp = lvl_sum[7:0];
		end
	end

	// arithmetic sequence
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			quot_q <= prod;
			part_q <= 16'd0;
			neg_q  <= diff_s[8];
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[22:0], fits};
			part_q <= fits ? 16'(shifted - {1'b0, cur_len}) : shifted[15:0];
		end
		if (cmd.level) begin
			level_q <= lvl_clamp;
		end
		if (cmd.square) begin
			sq_q <= {8'd0, level_q} * {8'd0, level_q};
		end
		if (cmd.cube) begin
			cube_q <= {8'd0, sq_q} * {16'd0, level_q};
		end
	end

	// motor decision and probe counter update
	logic [1:0] res_cmd;
	logic       res_probe;
	logic [7:0] res_level;
	logic [9:0] acc_next;
	logic [5:0] pw_inc;
	logic [5:0] pw_next;

	always_comb begin
		res_cmd   = rep_pkg::MOTOR_NONE;
		res_probe = 1'b0;
		res_level = 8'd0;
		acc_next  = cur_acc;
		pw_inc    = probe_wait_q + 6'd1;
		pw_next   = probe_wait_q;
		if (in_range && (func_q == rep_pkg::FUNC_TICK)) begin
			if (!pak_q) begin
				if (pw_inc > rep_pkg::PROBE_LIMIT) begin
					pw_next   = 6'd0;
					res_probe = 1'b1;
				end else begin
					pw_next = pw_inc;
				end
			end else begin
				res_level = level_q;
				priority if (level_q >= rep_pkg::LVL_START) begin
					if (!cur_run) res_cmd = rep_pkg::MOTOR_START;
				end else if (level_q < rep_pkg::LVL_STOP) begin
					if (cur_run) res_cmd = rep_pkg::MOTOR_STOP;
				end else if (cur_acc >= rep_pkg::ACC_STEP) begin
					acc_next = cur_acc - rep_pkg::ACC_STEP;
					if (!cur_run) res_cmd = rep_pkg::MOTOR_START;
				end else begin
					acc_next = cur_acc + cube_q[18:9] + rep_pkg::ACC_BIAS;
					if (cur_run) res_cmd = rep_pkg::MOTOR_STOP;
				end
			end
		end
	end

	// state update on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORTS; i++) begin
				ramp_start_q[i]     <= 8'd0;
				ramp_end_q[i]       <= 8'd0;
				ramp_length_q[i]    <= 16'd0;
				ramp_remaining_q[i] <= 16'd0;
				motor_running_q[i]  <= 1'b0;
				pulse_acc_q[i]      <= 10'd0;
			end
			probe_wait_q <= 6'd0;
		end else if (cmd.commit && in_range) begin
			if (func_q == rep_pkg::FUNC_LOAD) begin
				ramp_start_q[idx]     <= start_in_q;
				ramp_end_q[idx]       <= end_in_q;
				ramp_length_q[idx]    <= dur_in_q;
				ramp_remaining_q[idx] <= dur_in_q;
			end else if (!pak_q) begin
				probe_wait_q <= pw_next;
			end else begin
				pulse_acc_q[idx] <= acc_next;
				if (res_cmd == rep_pkg::MOTOR_START) begin
					motor_running_q[idx] <= 1'b1;
				end else if (res_cmd == rep_pkg::MOTOR_STOP) begin
					motor_running_q[idx] <= 1'b0;
				end
				if (ramp_on) begin
					ramp_remaining_q[idx] <= rem_dec;
					if (rem_dec == 16'd0) begin
						ramp_length_q[idx] <= 16'd0;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			motor_cmd_q <= res_cmd;
			probe_q     <= res_probe;
			level_out_q <= res_level;
		end
	end

	assign motor_cmd     = motor_cmd_q;
	assign probe_request = probe_q;
	assign level         = level_out_q;

endmodule

@@ src/rep_ctrl.sv @@
// rep_ctrl: sequencer for the rumble driver, request and result handshakes
// depends on rep_pkg; commands rep_dp through dp_cmd_t
module rep_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output rep_pkg::dp_cmd_t    cmd,
	input  rep_pkg::dp_status_t status
);

	rep_pkg::state_t               state_q;
	rep_pkg::state_t               state_next;
	logic [rep_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic                          out_valid_q;
	logic                          div_last;

	assign div_last = div_cnt_q == rep_pkg::DIV_CNT_W'(rep_pkg::DIV_STEPS - 1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rep_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state and commands
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			rep_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next  = rep_pkg::ST_MUL;
				end
			end
			rep_pkg::ST_MUL: begin
				if (status.calc) begin
					cmd.div_init = 1'b1;
					state_next   = rep_pkg::ST_DIV;
				end else begin
					state_next = rep_pkg::ST_DONE;
				end
			end
			rep_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_last) state_next = rep_pkg::ST_LEVEL;
			end
			rep_pkg::ST_LEVEL: begin
				cmd.level  = 1'b1;
				state_next = rep_pkg::ST_SQR;
			end
			rep_pkg::ST_SQR: begin
				cmd.square = 1'b1;
				state_next = rep_pkg::ST_CUBE;
			end
			rep_pkg::ST_CUBE: begin
				cmd.cube   = 1'b1;
				state_next = rep_pkg::ST_DONE;
			end
			rep_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_next = rep_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = rep_pkg::ST_IDLE;
			end
		endcase
	end

	// divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_init) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/rumble_envelope_pulse_driver.sv @@
// rumble_envelope_pulse_driver: top level, rep_ctrl sequencer plus rep_dp datapath
// a tick with a pak present runs the 24-step restoring divider
// loads, ticks without a pak and out-of-range ports skip the divider
// result sits in an output register; the next request is taken while it waits
// one request in flight; arst_n clears all ramp, motor, accumulator and probe state
// depends on rep_pkg, rep_ctrl and rep_dp
module rumble_envelope_pulse_driver #(
	parameter int PORTS = rep_pkg::PORTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [1:0]  controller,
	input  logic        pak_present,
	input  logic [7:0]  start_level,
	input  logic [7:0]  end_level,
	input  logic [15:0] duration,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  motor_cmd,
	output logic        probe_request,
	output logic [7:0]  level
);

	rep_pkg::dp_cmd_t    dp_cmd;
	rep_pkg::dp_status_t dp_status;

	// sequencer
	rep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (dp_cmd),
		.status    (dp_status)
	);

	// datapath
	rep_dp #(
		.PORTS (PORTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.status        (dp_status),
		.func          (func),
		.controller    (controller),
		.pak_present   (pak_present),
		.start_level   (start_level),
		.end_level     (end_level),
		.duration      (duration),
		.motor_cmd     (motor_cmd),
		.probe_request (probe_request),
		.level         (level)
	);

`ifndef NO_ASSERTIONS
	// busy right after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one still in flight");

	// a probe request carries no motor command and no level
	a_probe_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && probe_request |-> motor_cmd == rep_pkg::MOTOR_NONE && level == 8'd0)
		else $error("probe request mixed with motor result");

	// stop only below the start threshold
	a_stop_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && motor_cmd == rep_pkg::MOTOR_STOP |-> level < rep_pkg::LVL_START)
		else $error("stop issued at a full-on level");

	// start only at or above the stop threshold
	a_start_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && motor_cmd == rep_pkg::MOTOR_START |-> level >= rep_pkg::LVL_STOP)
		else $error("start issued at an off level");
`endif

endmodule

@@ bench/rumble_envelope_pulse_driver_tb.sv @@
// rumble_envelope_pulse_driver_tb: self-checking bench for the rumble motor driver,
// directed ramp/motor/probe cases then random ramp sequences against a local predictor
// depends on rep_pkg and rumble_envelope_pulse_driver
`timescale 1ns / 1ps

module rumble_envelope_pulse_driver_tb;

	localparam int PORTS           = rep_pkg::PORTS_DEF;
	localparam int RANDOM_REQUESTS = 1520;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int MAX_PRINTS      = 50;

	typedef struct packed {
		logic [1:0] motor_cmd;
		logic       probe_request;
		logic [7:0] level;
	} motor_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = rep_pkg::FUNC_TICK;
	logic [1:0]  controller = 2'd0;
	logic        pak_present = 1'b0;
	logic [7:0]  start_level = 8'd0;
	logic [7:0]  end_level = 8'd0;
	logic [15:0] duration = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  motor_cmd;
	logic        probe_request;
	logic [7:0]  level;

	// predictor state, one entry per port plus the shared probe counter
	logic [7:0]  ramp_from  [PORTS];
	logic [7:0]  ramp_to    [PORTS];
	logic [15:0] ramp_len   [PORTS];
	logic [15:0] ramp_left  [PORTS];
	logic        motor_live [PORTS];
	logic [9:0]  pulse_acc  [PORTS];
	logic [5:0]  probe_count;

	motor_result_t expected_results[$];
	motor_result_t want;
	int error_count = 0;
	int items_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	int ready_mode = 0;
	int mode_left = 0;

	rumble_envelope_pulse_driver #(
		.PORTS(PORTS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.controller   (controller),
		.pak_present  (pak_present),
		.start_level  (start_level),
		.end_level    (end_level),
		.duration     (duration),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.motor_cmd    (motor_cmd),
		.probe_request(probe_request),
		.level        (level)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// expected response of the driver to one accepted request, updates predictor state
	function automatic motor_result_t predict_motor_response(logic f, logic [1:0] c,
			logic pak, logic [7:0] s, logic [7:0] e, logic [15:0] d);
		motor_result_t r;
		int span;
		int elapsed;
		int lvl;
		int unsigned cube_term;
		logic [1:0] cmd;
		r = '0;
		cmd = rep_pkg::MOTOR_NONE;
		if (int'(c) >= PORTS)
			return r;
		// load: store the ramp, leave motor and accumulator alone
		if (f == rep_pkg::FUNC_LOAD) begin
			ramp_from[c] = s;
			ramp_to[c]   = e;
			ramp_len[c]  = d;
			ramp_left[c] = d;
			return r;
		end
		// tick without a pak only advances the shared probe counter
		if (!pak) begin
			probe_count = probe_count + 6'd1;
			if (probe_count > rep_pkg::PROBE_LIMIT) begin
				probe_count = '0;
				r.probe_request = 1'b1;
			end
			return r;
		end
		// ramp interpolation, truncating toward zero
		lvl = 0;
		if (ramp_len[c] != 16'd0) begin
			span    = int'(ramp_to[c]) - int'(ramp_from[c]);
			elapsed = int'(ramp_len[c]) - int'(ramp_left[c]);
			lvl     = span * elapsed / int'(ramp_len[c]) + int'(ramp_from[c]);
			ramp_left[c] = ramp_left[c] - 16'd1;
			if (ramp_left[c] == 16'd0)
				ramp_len[c] = 16'd0;
			if (lvl < 0)
				lvl = 0;
			if (lvl > 255)
				lvl = 255;
		end
		// motor decision: hard on, hard off, or pulse density in between
		if (lvl >= int'(rep_pkg::LVL_START)) begin
			if (!motor_live[c])
				cmd = rep_pkg::MOTOR_START;
		end else if (lvl < int'(rep_pkg::LVL_STOP)) begin
			if (motor_live[c])
				cmd = rep_pkg::MOTOR_STOP;
		end else if (pulse_acc[c] >= rep_pkg::ACC_STEP) begin
			pulse_acc[c] = pulse_acc[c] - rep_pkg::ACC_STEP;
			if (!motor_live[c])
				cmd = rep_pkg::MOTOR_START;
		end else begin
			cube_term = int'(lvl) * int'(lvl) * int'(lvl) / 512 + int'(rep_pkg::ACC_BIAS);
			pulse_acc[c] = pulse_acc[c] + cube_term[9:0];
			if (motor_live[c])
				cmd = rep_pkg::MOTOR_STOP;
		end
		if (cmd == rep_pkg::MOTOR_START)
			motor_live[c] = 1'b1;
		else if (cmd == rep_pkg::MOTOR_STOP)
			motor_live[c] = 1'b0;
		r.motor_cmd = cmd;
		r.level     = lvl[7:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $time);
	endtask

	// one request through the input handshake, with burst/gap pacing afterward
	task automatic send_request(input logic f, input logic [1:0] c, input logic pak,
			input logic [7:0] s, input logic [7:0] e, input logic [15:0] d);
		int gap;
		in_valid    <= 1'b1;
		func        <= f;
		controller  <= c;
		pak_present <= pak;
		start_level <= s;
		end_level   <= e;
		duration    <= d;
		do
			@(posedge clk);
		while (!in_ready);
		expected_results.push_back(predict_motor_response(f, c, pak, s, e, d));
		items_sent++;
		// end of burst: sometimes carry straight on, else go quiet for a while
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 10);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic tick(input logic [1:0] c, input logic pak);
		send_request(rep_pkg::FUNC_TICK, c, pak, 8'($urandom), 8'($urandom),
			16'($urandom));
	endtask

	task automatic load(input logic [1:0] c, input logic [7:0] s, input logic [7:0] e,
			input logic [15:0] d);
		send_request(rep_pkg::FUNC_LOAD, c, 1'($urandom), s, e, d);
	endtask

	// full-scale ramps, single-tick ramp, zero duration and a never-loaded port
	task automatic test_ramp_extremes();
		load(2'd0, 8'd255, 8'd0, 16'hFFFF);
		tick(2'd0, 1'b1);
		tick(2'd0, 1'b1);
		load(2'd1, 8'd0, 8'd255, 16'd1);
		tick(2'd1, 1'b1);
		tick(2'd1, 1'b1);
		load(2'd2, 8'd200, 8'd255, 16'd0);
		tick(2'd2, 1'b1);
		tick(2'd3, 1'b1);
	endtask

	// mid-range levels cycle the accumulator through add and subtract
	task automatic test_pulse_density();
		load(2'd1, 8'd70, 8'd70, 16'd8);
		repeat (5) tick(2'd1, 1'b1);
		load(2'd2, 8'd6, 8'd6, 16'd3);
		tick(2'd2, 1'b1);
	endtask

	// falling ramp crosses both thresholds, then a low level stops a running motor
	task automatic test_motor_start_stop();
		load(2'd3, 8'd100, 8'd0, 16'd4);
		repeat (5) tick(2'd3, 1'b1);
		load(2'd0, 8'd0, 8'd0, 16'd2);
		tick(2'd0, 1'b1);
	endtask

	// ticks with no pak leave the ramp alone and feed the probe counter
	task automatic test_no_pak();
		load(2'd2, 8'd90, 8'd10, 16'd5);
		tick(2'd2, 1'b0);
		tick(2'd2, 1'b1);
	endtask

	function automatic logic [7:0] pick_level();
		return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 90)) : 8'($urandom);
	endfunction

	// random ramp sequences on one port, plus noise and runs of pak-less ticks
	task automatic test_random_traffic(input int request_goal);
		int goal;
		int kind;
		int k;
		int sel;
		logic [1:0] port;
		logic [15:0] len;
		goal = items_sent + request_goal;
		while (items_sent < goal) begin
			kind = $urandom_range(0, 9);
			port = 2'($urandom);
			if (kind <= 5) begin
				sel = $urandom_range(0, 19);
				if (sel == 0)
					len = 16'd0;
				else if (sel == 1)
					len = 16'($urandom);
				else
					len = 16'($urandom_range(1, 24));
				load(port, pick_level(), pick_level(), len);
				k = $urandom_range(1, 30);
				repeat (k) begin
					sel = $urandom_range(0, 9);
					if (sel == 0)
						tick(2'($urandom), 1'($urandom));
					else if (sel == 1)
						tick(port, 1'b0);
					else
						tick(port, 1'b1);
				end
			end else if (kind <= 7) begin
				send_request(1'($urandom), port, 1'($urandom), 8'($urandom), 8'($urandom),
					16'($urandom));
			end else begin
				repeat ($urandom_range(1, 20)) tick(2'($urandom), 1'b0);
			end
		end
	endtask

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request pending", int'(level), 0);
			end else begin
				want = expected_results.pop_front();
				if (motor_cmd !== want.motor_cmd)
					report_mismatch("motor_cmd", int'(motor_cmd), int'(want.motor_cmd));
				if (probe_request !== want.probe_request)
					report_mismatch("probe_request", int'(probe_request),
						int'(want.probe_request));
				if (level !== want.level)
					report_mismatch("level", int'(level), int'(want.level));
			end
		end
		// modes: always ready, coin flip, mostly stalled, long stall runs
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(50, 400);
		end else begin
			mode_left--;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: begin
					stall_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 24);
					out_ready <= (stall_left == 0);
				end
			endcase
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles at %0t", idle_cycles, $time);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		for (int p = 0; p < PORTS; p++) begin
			ramp_from[p]  = '0;
			ramp_to[p]    = '0;
			ramp_len[p]   = '0;
			ramp_left[p]  = '0;
			motor_live[p] = 1'b0;
			pulse_acc[p]  = '0;
		end
		probe_count = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ramp_extremes();
		test_pulse_density();
		test_motor_start_stop();
		test_no_pak();
		test_random_traffic(RANDOM_REQUESTS);

		if (in_valid)
			in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
